>>> sv/b100r_pkg.sv
// Package for the base-100 decimal rounding unit.
// Operation codes and a shared digit helper; no dependencies.
package b100r_pkg;

    typedef enum logic [1:0] {
        MODE_CEIL  = 2'd0,
        MODE_FLOOR = 2'd1,
        MODE_ROUND = 2'd2,
        MODE_TRUNC = 2'd3
    } mode_t;

    localparam int DIGIT_W   = 7;
    localparam int WORD_W    = 56;
    localparam int MAX_EXP   = 63;

    // digit value mod 10 for 0..127, quotient by reciprocal multiply (205 / 2048)
    function automatic logic [3:0] mod10(input logic [6:0] d);
        logic [6:0] q;
        logic [17:0] p;
        logic [6:0] r;
        begin
            p = 18'(d) * 18'd205;
            q = 7'(p >> 11);
            r = d - 7'(q * 7'd10);
            if (r >= 7'd10)
                r = r - 7'd10;
            mod10 = r[3:0];
        end
    endfunction

endpackage

>>> sv/base100_decimal_rounding_unit.sv
// Top level of the base-100 decimal rounding unit.
// Uses b100r_pkg for the operation codes and the mod-10 helper.
//
// Usage: one number enters on the s_axis channel, one result leaves on the
// m_axis channel, in order. s_axis_tdata packs, from bit 0 up: mode(2),
// in_null, in_zero, in_negative, in_exponent(7), in_mant_high, in_mant_mid,
// in_mant_low (56 each), places(9), places_null, zero fill.
// m_axis_tdata packs: out_null, out_zero, out_negative, out_exponent(7),
// out_mant_high, out_mant_mid, out_mant_low, overflow, zero fill.
// Four register stages: decode and position, fraction scan and digit
// adjust, carry ripple, then renormalize and pack into the output register.
// One item per cycle sustained while m_axis is ready. The carry ripple is
// split as a look-ahead over DIGITS digits (generate/propagate per digit).
// Stages advance only when the stage ahead is empty or moving, so a stall
// at m_axis holds every item in place; s_axis_tready falls only when all
// stages are full and the output is not taken.
// Reset clears all valid bits; payload registers are not reset.
module base100_decimal_rounding_unit #(
    parameter int DIGITS = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // mode,in_null,in_zero,in_negative,in_exponent,
                                         // in_mant_high,in_mant_mid,in_mant_low,places,
                                         // places_null
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [183:0] m_axis_tdata    // out_null,out_zero,out_negative,out_exponent,
                                         // out_mant_high,out_mant_mid,out_mant_low,overflow
);
    import b100r_pkg::*;

    localparam int KW = 9; // digit position, signed, wide enough for -192..190

    typedef logic [DIGIT_W-1:0] digs_t [DIGITS];

    // ---------------- stage 0: unpack ----------------
    logic [1:0]        i_mode;
    logic              i_null, i_zero, i_neg, i_pnull;
    logic signed [6:0] i_exp;
    logic signed [8:0] i_places;
    logic [3*WORD_W-1:0] i_mant;
    digs_t             i_m;

    assign i_mode   = s_axis_tdata[1:0];
    assign i_null   = s_axis_tdata[2];
    assign i_zero   = s_axis_tdata[3];
    assign i_neg    = s_axis_tdata[4];
    assign i_exp    = s_axis_tdata[11:5];
    assign i_mant   = {s_axis_tdata[67:12], s_axis_tdata[123:68], s_axis_tdata[179:124]};
    assign i_places = s_axis_tdata[188:180];
    assign i_pnull  = s_axis_tdata[189];

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
            i_m[i] = i_mant[3*WORD_W-1-DIGIT_W*i -: DIGIT_W];
    end

    // kind of work for an item
    typedef enum logic [2:0] {
        K_NULL, K_ZERO, K_UP, K_TRUNCINT, K_RND_ALL, K_RND
    } kind_t;

    // ---------------- handshake ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic a1, a2, a3, a4;
    assign a4 = !v4_reg || m_axis_tready;
    assign a3 = !v3_reg || a4;
    assign a2 = !v2_reg || a3;
    assign a1 = !v1_reg || a2;
    assign s_axis_tready = a1;
    assign m_axis_tvalid = v4_reg;

    // ---------------- stage 1 register ----------------
    kind_t             k1_reg;
    logic              n1_reg, rnd1_reg, odd1_reg;
    logic signed [KW-1:0] e1_reg, r1_reg;
    digs_t             m1_reg;

    logic              s_pn;
    logic signed [KW+1:0] s_r;
    kind_t             s_k;

    always_comb
    begin
        s_pn = i_pnull;
        s_r  = -(KW+2)'(i_places);
        if (i_null || (i_mode[1] && s_pn))
            s_k = K_NULL;
        else if (i_zero)
            s_k = K_ZERO;
        else if ((i_mode == MODE_CEIL && !i_neg) || (i_mode == MODE_FLOOR && i_neg))
            s_k = K_UP;
        else if (!i_mode[1])
            s_k = (i_exp <= 0) ? K_ZERO : K_TRUNCINT;
        else if ((KW+2)'(2 * i_exp) <= s_r)
            s_k = ((KW+2)'(2 * i_exp) == s_r && i_mode == MODE_ROUND && i_m[0] >= 7'd50)
                  ? K_RND_ALL : K_ZERO;
        else
            s_k = K_RND;
    end

    logic signed [KW-1:0] s_kpos;
    logic s_odd;
    always_comb
    begin
        s_odd = s_r[0];
        if (!s_odd)
            s_kpos = KW'((KW+2)'(i_exp) - (s_r >>> 1));
        else if (!s_r[KW+1])
            s_kpos = KW'((KW+2)'(i_exp) - ((s_r - 1) >>> 1) - 1);
        else
            s_kpos = KW'((KW+2)'(i_exp) - ((s_r + 1) >>> 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (a1)
            v1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (a1 && s_axis_tvalid)
        begin
            k1_reg   <= s_k;
            n1_reg   <= i_neg;
            rnd1_reg <= (i_mode == MODE_ROUND);
            odd1_reg <= s_odd;
            e1_reg   <= KW'(i_exp);
            r1_reg   <= (s_k == K_RND) ? s_kpos : KW'(i_exp);
            m1_reg   <= i_m;
        end
    end

    // ---------------- stage 2: fraction scan, digit adjust, mask ----------------
    // After this stage: digits to keep, an increment digit mask (add 1 at
    // position p, or 10 for the odd case), ready for the carry stage.
    digs_t  c_m;
    logic [DIGIT_W-1:0] c_add [DIGITS];
    logic   c_frac, c_doadd, c_allneg;
    logic signed [KW-1:0] c_e;
    kind_t  c_k;

    always_comb
    begin
        c_m = m1_reg;
        c_e = e1_reg;
        c_k = k1_reg;
        c_frac = 1'b0;
        c_doadd = 1'b0;
        c_allneg = 1'b0;
        for (int i = 0; i < DIGITS; i++)
            c_add[i] = '0;
        unique case (k1_reg)
            K_UP:
            begin
                if (e1_reg < 0)
                begin
                    for (int i = 0; i < DIGITS; i++)
                        c_m[i] = '0;
                    c_m[0] = 7'd1;
                    c_e = KW'(1);
                end
                else if (e1_reg < KW'(DIGITS))
                begin
                    for (int i = 0; i < DIGITS; i++)
                        if (KW'(i) >= e1_reg && m1_reg[i] != '0)
                            c_frac = 1'b1;
                    for (int i = 0; i < DIGITS; i++)
                        if (KW'(i) >= e1_reg)
                            c_m[i] = '0;
                    // add 1 at digit e-1; if e==0 it is a pure carry out
                    if (c_frac)
                    begin
                        if (e1_reg == 0)
                            c_allneg = 1'b1;
                        else
                            for (int i = 0; i < DIGITS; i++)
                                if (KW'(i) == e1_reg - 1)
                                    c_add[i] = 7'd1;
                    end
                end
            end
            K_TRUNCINT:
            begin
                for (int i = 0; i < DIGITS; i++)
                    if (KW'(i) >= e1_reg)
                        c_m[i] = '0;
            end
            K_RND:
            begin
                c_doadd = 1'b1;
                if (odd1_reg)
                begin
                    if (r1_reg >= 0 && r1_reg < KW'(DIGITS))
                        for (int i = 0; i < DIGITS; i++)
                        begin
                            if (KW'(i) == r1_reg)
                            begin
                                c_m[i] = m1_reg[i] - 7'(mod10(m1_reg[i]));
                                if (rnd1_reg && mod10(m1_reg[i]) >= 4'd5)
                                    c_add[i] = 7'd10;
                            end
                            else if (KW'(i) > r1_reg)
                                c_m[i] = '0;
                        end
                end
                else if (r1_reg >= 1 && r1_reg < KW'(DIGITS))
                begin
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        if (KW'(i) >= r1_reg)
                            c_m[i] = '0;
                        if (rnd1_reg && KW'(i + 1) == r1_reg && m1_reg[i + 1 < DIGITS ? i + 1 : i] >= 7'd50)
                            c_add[i] = 7'd1;
                    end
                end
                if (!rnd1_reg)
                    c_doadd = 1'b0;
            end
            default: ;
        endcase
    end

    kind_t  k2_reg;
    logic   n2_reg, sub2_reg, top2_reg;
    logic signed [KW-1:0] e2_reg;
    digs_t  m2_reg;
    logic [DIGIT_W:0] s2_reg [DIGITS];  // digit plus addend, up to 8 bits
    logic   cin2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (a2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a2 && v1_reg)
        begin
            k2_reg   <= c_k;
            n2_reg   <= n1_reg;
            e2_reg   <= c_e;
            m2_reg   <= c_m;
            // K_UP ripples only when a fraction was found; K_RND ripples when rounding
            sub2_reg <= (c_k == K_RND) ? c_doadd : ((c_k == K_UP) && c_frac);
            top2_reg <= c_allneg;
            cin2_reg <= (c_k == K_UP) && (e1_reg >= KW'(DIGITS));
            for (int i = 0; i < DIGITS; i++)
                s2_reg[i] <= {1'b0, c_m[i]} + {1'b0, c_add[i]};
        end
    end

    // ---------------- stage 3: carry look-ahead ----------------
    // sequential semantics: value v+carry, if >=100 subtract 100 and carry.
    // generate g = v>=100, propagate p = v==99. Carry into digit i is OR over j>i
    // of g[j] & AND p[i+1..j-1]. Since v<=127 and carry adds 1, v>=100 with
    // carry gives v+1-100 and carry; matches the model.
    logic [DIGITS-1:0] g3, p3, cy;
    digs_t  o_m;
    logic   o_cout;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            g3[i] = s2_reg[i] >= 8'd100;
            p3[i] = s2_reg[i] == 8'd99;
        end
        cy[DIGITS-1] = 1'b0;
        for (int i = DIGITS - 2; i >= 0; i--)
            cy[i] = g3[i + 1] | (p3[i + 1] & cy[i + 1]);
        o_cout = g3[0] | (p3[0] & cy[0]);
        for (int i = 0; i < DIGITS; i++)
        begin
            logic [DIGIT_W:0] t;
            t = s2_reg[i] + {7'd0, cy[i]};
            o_m[i] = (t >= 8'd100) ? DIGIT_W'(t - 8'd100) : t[DIGIT_W-1:0];
        end
        if (!sub2_reg)
            o_m = m2_reg;
    end

    kind_t  k3_reg;
    logic   n3_reg, co3_reg;
    logic signed [KW-1:0] e3_reg;
    digs_t  m3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (a3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a3 && v2_reg)
        begin
            k3_reg  <= k2_reg;
            n3_reg  <= n2_reg;
            e3_reg  <= e2_reg;
            m3_reg  <= o_m;
            co3_reg <= sub2_reg && !cin2_reg && (o_cout || top2_reg);
        end
    end

    // ---------------- stage 4: renormalize and pack ----------------
    digs_t  f_m;
    logic signed [KW-1:0] f_e;
    logic   f_null, f_zero, f_ovf;
    logic [183:0] f_data;
    logic [3*WORD_W-1:0] f_w;

    always_comb
    begin
        f_m = m3_reg;
        f_e = e3_reg;
        f_null = (k3_reg == K_NULL);
        f_zero = (k3_reg == K_ZERO);
        if (k3_reg == K_RND_ALL)
        begin
            for (int i = 0; i < DIGITS; i++)
                f_m[i] = '0;
            f_m[0] = 7'd1;
            f_e = e3_reg + KW'(1);
        end
        else if (co3_reg)
        begin
            if (k3_reg == K_UP)
            begin
                // shift digits 0..e-1 right, top becomes 1, clear from e+1
                for (int i = 1; i < DIGITS; i++)
                    f_m[i] = (KW'(i) <= e3_reg) ? m3_reg[i - 1] : '0;
            end
            else
                for (int i = 1; i < DIGITS; i++)
                    f_m[i] = m3_reg[i - 1];
            f_m[0] = 7'd1;
            f_e = e3_reg + KW'(1);
        end
        f_ovf = (k3_reg == K_UP || k3_reg == K_RND || k3_reg == K_RND_ALL) &&
                (f_e > KW'(MAX_EXP));
        if (k3_reg == K_RND && !f_ovf && f_m[0] == '0)
            f_zero = 1'b1;
        f_w = '0;
        for (int i = 0; i < DIGITS; i++)
            f_w[3*WORD_W-1-DIGIT_W*i -: DIGIT_W] = f_m[i];
        f_data = '0;
        if (f_null)
            f_data[0] = 1'b1;
        else if (f_ovf)
            f_data[178] = 1'b1;
        else if (f_zero)
            f_data[1] = 1'b1;
        else
        begin
            f_data[2]      = n3_reg;
            f_data[9:3]    = f_e[6:0];
            f_data[65:10]  = f_w[167:112];
            f_data[121:66] = f_w[111:56];
            f_data[177:122] = f_w[55:0];
        end
    end

    logic [183:0] d4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (a4)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a4 && v3_reg)
            d4_reg <= f_data;
    end

    assign m_axis_tdata = d4_reg;

endmodule
